### sv/e2q_pkg.sv
// Shared constants, types and an arctangent table function for the Euler-to-quaternion block.
// No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int TRIG_STAGES_DEF = 16;
  localparam int TABLE_LEN       = 24;
  localparam int QW              = 34;
  localparam logic signed [QW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [QW-1:0] PI_Q30  = 34'sd3373259426;
  localparam logic signed [QW-1:0] GAIN    = 34'sd652032874;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } rot_t;

  function automatic q_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sd843314857;
      1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043837;
      3: atan_q30 = 34'sd133525159;
      4: atan_q30 = 34'sd67021687;
      5: atan_q30 = 34'sd33543516;
      6: atan_q30 = 34'sd16775851;
      7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194283;
      9: atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048576;
      11: atan_q30 = 34'sd524288;
      12: atan_q30 = 34'sd262144;
      13: atan_q30 = 34'sd131072;
      14: atan_q30 = 34'sd65536;
      15: atan_q30 = 34'sd32768;
      16: atan_q30 = 34'sd16384;
      17: atan_q30 = 34'sd8192;
      18: atan_q30 = 34'sd4096;
      19: atan_q30 = 34'sd2048;
      20: atan_q30 = 34'sd1024;
      21: atan_q30 = 34'sd512;
      22: atan_q30 = 34'sd256;
      23: atan_q30 = 34'sd128;
      default: atan_q30 = '0;
    endcase
  endfunction
endpackage

### sv/euler_to_quaternion_top.sv
// Top level: yaw select, range fold, CORDIC cell chain, products, output stage.
// Depends on e2q_pkg, e2q_cell, e2q_prod.
//
//   channel | dir | tdata fields (low bit up)
//   s_axis  | in  | roll, pitch, commanded_yaw, measured_yaw, rotate_right, rotate_left
//   m_axis  | out | quat_w, quat_x, quat_y, quat_z, yaw_used
//
// One item per cycle while the output stage is not stalled.
// The pipe advances when the output stage is empty or taken; a stall holds all.
// Reset clears only valid bits.
`timescale 1ns / 1ps
module euler_to_quaternion_top #(
  parameter int ANGLE_BITS  = e2q_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // roll, pitch, commanded_yaw, measured_yaw, rotate_right, rotate_left
  input  logic [((4*ANGLE_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, yaw_used
  output logic [((64+ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata
);
  localparam int AB = ANGLE_BITS;
  localparam int QW = e2q_pkg::QW;
  localparam int LAT = TRIG_STAGES + 5;
  localparam int OW = ((64 + AB + 7) / 8) * 8;

  logic en;
  logic [LAT-1:0] v_q;
  logic [AB-1:0] yaw_pipe_q [LAT];
  logic [LAT-1:0] neg_pipe_q [3];
  logic [AB-1:0] ang [3];
  logic [AB-1:0] yaw_w;
  e2q_pkg::rot_t r0_q [3];
  e2q_pkg::rot_t r0_d [3];
  e2q_pkg::rot_t chain [TRIG_STAGES+1][3];
  logic [2:0] neg_d;
  e2q_pkg::q_t cs_q [6];
  logic signed [15:0] qv [4];
  logic ov_q;
  logic [OW-1:0] od_q;

  assign en = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  assign yaw_w = (s_axis_tdata[4*AB] | s_axis_tdata[4*AB+1]) ?
                 s_axis_tdata[3*AB-1:2*AB] : s_axis_tdata[4*AB-1:3*AB];
  assign ang[0] = s_axis_tdata[AB-1:0];
  assign ang[1] = s_axis_tdata[2*AB-1:AB];
  assign ang[2] = yaw_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e2q_pkg::q_t z;
      z = e2q_pkg::q_t'($signed(ang[k])) <<< (32 - AB);
      neg_d[k] = 1'b0;
      if (z > e2q_pkg::HALF_PI) begin
        z = z - e2q_pkg::PI_Q30; neg_d[k] = 1'b1;
      end else if (z < -e2q_pkg::HALF_PI) begin
        z = z + e2q_pkg::PI_Q30; neg_d[k] = 1'b1;
      end
      r0_d[k].x = e2q_pkg::GAIN;
      r0_d[k].y = '0;
      r0_d[k].z = z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q <= r0_d;
      yaw_pipe_q[0] <= yaw_w;
      for (int j = 1; j < LAT; j++) yaw_pipe_q[j] <= yaw_pipe_q[j-1];
      for (int k = 0; k < 3; k++) neg_pipe_q[k] <= {neg_pipe_q[k][LAT-2:0], neg_d[k]};
      for (int k = 0; k < 3; k++) begin
        cs_q[2*k]   <= neg_pipe_q[k][TRIG_STAGES] ?
                       -chain[TRIG_STAGES][k].x : chain[TRIG_STAGES][k].x;
        cs_q[2*k+1] <= neg_pipe_q[k][TRIG_STAGES] ?
                       -chain[TRIG_STAGES][k].y : chain[TRIG_STAGES][k].y;
      end
    end
  end

  assign chain[0] = r0_q;
  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    e2q_cell #(.STAGE(g)) u_cell (
      .clk_i(clk_i), .en_i(en), .r_i(chain[g]), .r_o(chain[g+1])
    );
  end

  e2q_prod u_prod (.clk_i(clk_i), .en_i(en), .cs_i(cs_q), .q_o(qv));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[LAT-2:0], s_axis_tvalid};
      ov_q <= v_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) od_q <= OW'({yaw_pipe_q[LAT-1], qv[3], qv[2], qv[1], qv[0]});
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("stalled with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[LAT-1] |=> m_axis_tvalid) else $error("item lost at output");
endmodule

### sv/e2q_cell.sv
// One CORDIC rotation cell for the three angle lanes, registered output.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  e2q_pkg::rot_t r_i [3],
  output e2q_pkg::rot_t r_o [3]
);
  e2q_pkg::rot_t r_d [3];
  e2q_pkg::rot_t r_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!r_i[k].z[e2q_pkg::QW-1]) begin
        r_d[k].x = r_i[k].x - (r_i[k].y >>> STAGE);
        r_d[k].y = r_i[k].y + (r_i[k].x >>> STAGE);
        r_d[k].z = r_i[k].z - e2q_pkg::atan_q30(STAGE);
      end else begin
        r_d[k].x = r_i[k].x + (r_i[k].y >>> STAGE);
        r_d[k].y = r_i[k].y - (r_i[k].x >>> STAGE);
        r_d[k].z = r_i[k].z + e2q_pkg::atan_q30(STAGE);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_q <= r_d;
  end

  assign r_o = r_q;
endmodule

### sv/e2q_prod.sv
// Triple-product and combine stages forming the quaternion parts.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_prod (
  input  logic                clk_i,
  input  logic                en_i,
  input  e2q_pkg::q_t         cs_i [6],
  output logic signed [15:0]  q_o  [4]
);
  // cs_i order: cr sr cp sp cy sy
  localparam int PW = 2 * e2q_pkg::QW;
  e2q_pkg::q_t pq [8];
  e2q_pkg::q_t p1_q [8];
  e2q_pkg::q_t t_q  [8];
  e2q_pkg::q_t c_q  [8];
  logic signed [PW-1:0] m1 [8];
  logic signed [PW-1:0] m2 [8];
  logic signed [e2q_pkg::QW:0] s [4];
  logic signed [e2q_pkg::QW:0] rr [4];
  logic signed [15:0] q_q [4];
  // pairs (a,b,c): ccc sss scc css csc scs ccs ssc
  localparam int IA [8] = '{0, 1, 1, 0, 0, 1, 0, 1};
  localparam int IB [8] = '{2, 3, 2, 3, 3, 2, 2, 3};
  localparam int IC [8] = '{4, 5, 4, 5, 4, 5, 5, 4};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      m1[k] = cs_i[IA[k]] * cs_i[IB[k]];
      pq[k] = e2q_pkg::q_t'(m1[k] >>> 30);
      m2[k] = p1_q[k] * c_q[k];
    end
    s[0] = {t_q[0][e2q_pkg::QW-1], t_q[0]} + {t_q[1][e2q_pkg::QW-1], t_q[1]};
    s[1] = {t_q[2][e2q_pkg::QW-1], t_q[2]} - {t_q[3][e2q_pkg::QW-1], t_q[3]};
    s[2] = {t_q[4][e2q_pkg::QW-1], t_q[4]} + {t_q[5][e2q_pkg::QW-1], t_q[5]};
    s[3] = {t_q[6][e2q_pkg::QW-1], t_q[6]} - {t_q[7][e2q_pkg::QW-1], t_q[7]};
    for (int k = 0; k < 4; k++) begin
      rr[k] = (s[k] + 35'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 8; k++) begin
        p1_q[k] <= pq[k];
        c_q[k]  <= cs_i[IC[k]];
        t_q[k]  <= e2q_pkg::q_t'(m2[k] >>> 30);
      end
      for (int k = 0; k < 4; k++) begin
        if (rr[k] > 35'sd16384) q_q[k] <= 16'sd16384;
        else if (rr[k] < -35'sd16384) q_q[k] <= -16'sd16384;
        else q_q[k] <= rr[k][15:0];
      end
    end
  end

  assign q_o = q_q;
endmodule
